// ===== rtl/ptst_pkg.sv =====
// Shared constants, codes and control types for the timer slot table.
// No dependencies; imported by the interfaces and every module of the block.
`timescale 1ns / 1ps

package ptst_pkg;

    // Table geometry
    localparam int SLOTS        = 8;
    localparam int PERIOD_WIDTH = 16;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Fixed field widths
    localparam int ACTION_W  = 2;
    localparam int TICKS_W   = 16;
    localparam int TAG_W     = 8;
    localparam int INDEX_W   = 8;
    localparam int KIND_W    = 2;
    localparam int SLOTNUM_W = 3;

    // Helper widths for extend-then-select
    localparam int SLOT_EXT_W   = (SLOT_W > SLOTNUM_W) ? SLOT_W : SLOTNUM_W;
    localparam int PERIOD_EXT_W = (PERIOD_WIDTH > TICKS_W) ? PERIOD_WIDTH : TICKS_W;

    // Request actions
    localparam logic [ACTION_W-1:0] ACT_REGISTER   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UNREGISTER = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK       = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_REG   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNREG = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } ptst_state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;      // capture the accepted request
        logic exec;       // perform register / unregister and load the reply
        logic scan_step;  // process the slot under the scan pointer
        logic emit_done;  // load the tick-done result
    } ptst_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;     // latched action
        logic                out_free;   // result register can take a value
        logic                scan_fire;  // current slot fires on this tick
        logic                scan_last;  // scan pointer on the last slot
    } ptst_sts_t;

    // Slot index to the 3-bit result field (low bits kept)
    function automatic logic [SLOTNUM_W-1:0] slot_num(input logic [SLOT_W-1:0] idx);
        logic [SLOT_EXT_W-1:0] ext;
        ext = SLOT_EXT_W'(idx);
        return ext[SLOTNUM_W-1:0];
    endfunction

endpackage

// ===== rtl/ptst_if.sv =====
// Valid/ready channel interfaces for requests and results of the timer slot table.
// Depends on ptst_pkg for field widths.
`timescale 1ns / 1ps

interface ptst_req_if
    import ptst_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [TICKS_W-1:0]  period_ticks;
    logic                repeat_mode;
    logic [TAG_W-1:0]    event_tag;
    logic [INDEX_W-1:0]  slot_index;

    modport source (
        output valid, action, period_ticks, repeat_mode, event_tag, slot_index,
        input  ready
    );
    modport sink (
        input  valid, action, period_ticks, repeat_mode, event_tag, slot_index,
        output ready
    );
endinterface

interface ptst_rsp_if
    import ptst_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    result_kind;
    logic [SLOTNUM_W-1:0] slot_number;
    logic                 success;
    logic [TAG_W-1:0]     fired_tag;
    logic                 last_of_run;

    modport source (
        output valid, result_kind, slot_number, success, fired_tag, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, result_kind, slot_number, success, fired_tag, last_of_run,
        output ready
    );
endinterface

// ===== rtl/ptst_ctrl.sv =====
// Sequencing state machine for the timer slot table.
// Depends on ptst_pkg; drives ptst_dp through ptst_cmd_t and reads ptst_sts_t.
`timescale 1ns / 1ps

module ptst_ctrl
    import ptst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  ptst_sts_t sts,
    output ptst_cmd_t cmd
);

    ptst_state_t state_reg;
    ptst_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.action)
                    ACT_REGISTER:   state_next = ST_EXEC;
                    ACT_UNREGISTER: state_next = ST_EXEC;
                    ACT_TICK:       state_next = ST_SCAN;
                    default:        state_next = ST_IDLE;  // unknown action: no result
                endcase
            end
            ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                // a firing slot waits for room in the result register
                if (!sts.scan_fire || sts.out_free)
                begin
                    cmd.scan_step = 1'b1;
                    if (sts.scan_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ptst_dp.sv =====
// Slot storage, scan pointer, request capture and result register.
// Depends on ptst_pkg; commanded by ptst_ctrl.
`timescale 1ns / 1ps

module ptst_dp
    import ptst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptst_cmd_t            cmd,
    output ptst_sts_t            sts,
    // captured request fields
    input  logic [ACTION_W-1:0]  action,
    input  logic [TICKS_W-1:0]   period_ticks,
    input  logic                 repeat_mode,
    input  logic [TAG_W-1:0]     event_tag,
    input  logic [INDEX_W-1:0]   slot_index,
    // result channel
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [KIND_W-1:0]    result_kind,
    output logic [SLOTNUM_W-1:0] slot_number,
    output logic                 success,
    output logic [TAG_W-1:0]     fired_tag,
    output logic                 last_of_run
);

    // Captured request
    logic [ACTION_W-1:0] act_reg;
    logic [TICKS_W-1:0]  period_reg;
    logic                rep_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [INDEX_W-1:0]  idx_reg;

    // Slot storage; only busy entries are ever read
    logic [SLOTS-1:0]        busy_reg;
    logic [SLOTS-1:0]        busy_next;
    logic [PERIOD_WIDTH-1:0] per_mem [SLOTS];
    logic [PERIOD_WIDTH-1:0] cnt_mem [SLOTS];
    logic                    rep_mem [SLOTS];
    logic [TAG_W-1:0]        tag_mem [SLOTS];

    // Scan pointer
    logic [SLOT_W-1:0] scan_reg;
    logic [SLOT_W-1:0] scan_next;

    // Result register
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic [KIND_W-1:0]    kind_reg;
    logic [KIND_W-1:0]    kind_next;
    logic [SLOTNUM_W-1:0] slot_reg;
    logic [SLOTNUM_W-1:0] slot_next;
    logic                 ok_reg;
    logic                 ok_next;
    logic [TAG_W-1:0]     ftag_reg;
    logic [TAG_W-1:0]     ftag_next;
    logic                 last_reg;
    logic                 last_next;

    // Decode helpers
    logic                    free_found;
    logic [SLOT_W-1:0]       free_idx;
    logic [PERIOD_EXT_W-1:0] per_ext;
    logic [PERIOD_WIDTH-1:0] per_mask;
    logic [PERIOD_WIDTH-1:0] per_eff;
    logic                    do_reg;
    logic                    do_unreg;
    logic                    idx_in_range;
    logic [SLOT_W-1:0]       unreg_slot;
    logic                    unreg_busy;
    logic                    cur_busy;
    logic [PERIOD_WIDTH-1:0] cur_dec;
    logic                    cur_fire;
    logic                    cur_last;
    logic                    out_free;
    logic                    load;
    logic                    cnt_we;
    logic [SLOT_W-1:0]       cnt_addr;
    logic [PERIOD_WIDTH-1:0] cnt_wdata;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg    <= action;
            period_reg <= period_ticks;
            rep_reg    <= repeat_mode;
            tag_reg    <= event_tag;
            idx_reg    <= slot_index;
        end
    end

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Period masked to the stored width, zero promoted to one
    always_comb
    begin
        per_ext  = PERIOD_EXT_W'(period_reg);
        per_mask = per_ext[PERIOD_WIDTH-1:0];
        per_eff  = (per_mask == '0) ? PERIOD_WIDTH'(1) : per_mask;
    end

    // Register / unregister decode
    assign do_reg       = cmd.exec && (act_reg == ACT_REGISTER);
    assign do_unreg     = cmd.exec && (act_reg == ACT_UNREGISTER);
    assign idx_in_range = (idx_reg < INDEX_W'(SLOTS));
    assign unreg_slot   = idx_reg[SLOT_W-1:0];
    assign unreg_busy   = idx_in_range && busy_reg[unreg_slot];

    // Slot under the scan pointer
    assign cur_busy = busy_reg[scan_reg];
    assign cur_dec  = cnt_mem[scan_reg] - PERIOD_WIDTH'(1);
    assign cur_fire = cur_busy && (cur_dec == '0);
    assign cur_last = (scan_reg == SLOT_W'(SLOTS - 1));

    assign out_free = !rsp_valid_reg || rsp_ready;

    // Busy flags
    always_comb
    begin
        busy_next = busy_reg;
        if (do_reg && free_found)
        begin
            busy_next[free_idx] = 1'b1;
        end
        if (do_unreg && idx_in_range)
        begin
            busy_next[unreg_slot] = 1'b0;
        end
        if (cmd.scan_step && cur_fire && !rep_mem[scan_reg])
        begin
            busy_next[scan_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // Counter write port: load on register, decrement or reload on scan
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_addr  = scan_reg;
        cnt_wdata = cur_dec;
        if (do_reg && free_found)
        begin
            cnt_we    = 1'b1;
            cnt_addr  = free_idx;
            cnt_wdata = per_eff;
        end
        else if (cmd.scan_step && cur_busy)
        begin
            cnt_we    = 1'b1;
            cnt_wdata = cur_fire ? per_mem[scan_reg] : cur_dec;
        end
    end

    // Slot arrays
    always_ff @(posedge clk)
    begin
        if (do_reg && free_found)
        begin
            per_mem[free_idx] <= per_eff;
            rep_mem[free_idx] <= rep_reg;
            tag_mem[free_idx] <= tag_reg;
        end
        if (cnt_we)
        begin
            cnt_mem[cnt_addr] <= cnt_wdata;
        end
    end

    // Scan pointer: cleared on capture, one slot per step
    always_comb
    begin
        scan_next = scan_reg;
        if (cmd.latch)
        begin
            scan_next = '0;
        end
        else if (cmd.scan_step && !cur_last)
        begin
            scan_next = scan_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    // Result payload select
    always_comb
    begin
        load      = 1'b1;
        kind_next = KIND_DONE;
        slot_next = '0;
        ok_next   = 1'b1;
        ftag_next = '0;
        last_next = 1'b1;
        if (do_reg)
        begin
            kind_next = KIND_REG;
            slot_next = free_found ? slot_num(free_idx) : '0;
            ok_next   = free_found;
        end
        else if (do_unreg)
        begin
            kind_next = KIND_UNREG;
            slot_next = idx_in_range ? idx_reg[SLOTNUM_W-1:0] : '0;
            ok_next   = unreg_busy;
        end
        else if (cmd.scan_step && cur_fire)
        begin
            kind_next = KIND_FIRE;
            slot_next = slot_num(scan_reg);
            ftag_next = tag_mem[scan_reg];
            last_next = 1'b0;
        end
        else if (!cmd.emit_done)
        begin
            load = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= kind_next;
            slot_reg <= slot_next;
            ok_reg   <= ok_next;
            ftag_reg <= ftag_next;
            last_reg <= last_next;
        end
    end

    // Outputs and status
    assign rsp_valid   = rsp_valid_reg;
    assign result_kind = kind_reg;
    assign slot_number = slot_reg;
    assign success     = ok_reg;
    assign fired_tag   = ftag_reg;
    assign last_of_run = last_reg;

    assign sts.action    = act_reg;
    assign sts.out_free  = out_free;
    assign sts.scan_fire = cur_fire;
    assign sts.scan_last = cur_last;

endmodule

// ===== rtl/periodic_timer_slot_table.sv =====
// Top level of the timer slot table: controller plus datapath.
// Depends on ptst_pkg, ptst_if, ptst_ctrl and ptst_dp.
//
//  Port  | Dir | Carries
//  ------+-----+----------------------------------------------------------
//  req   | in  | action, period_ticks, repeat_mode, event_tag, slot_index
//  rsp   | out | result_kind, slot_number, success, fired_tag, last_of_run
//
// One request at a time. Register and unregister go through dispatch and
// execute before the next accept; an unknown action leaves after dispatch.
// A tick scans one slot per cycle, unless stalled, through the counter array.
// Each result sits in one output register, so a stalled result consumer holds
// the scan on a firing slot until that register frees up.
// Reset clears the busy flags at once; no clearing pass is needed.
`timescale 1ns / 1ps

module periodic_timer_slot_table
    import ptst_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    ptst_req_if.sink   req,
    ptst_rsp_if.source rsp
);

    ptst_cmd_t cmd;
    ptst_sts_t sts;

    ptst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ptst_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .action       (req.action),
        .period_ticks (req.period_ticks),
        .repeat_mode  (req.repeat_mode),
        .event_tag    (req.event_tag),
        .slot_index   (req.slot_index),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .result_kind  (rsp.result_kind),
        .slot_number  (rsp.slot_number),
        .success      (rsp.success),
        .fired_tag    (rsp.fired_tag),
        .last_of_run  (rsp.last_of_run)
    );

endmodule

// ===== rtl/ptst_chk.sv =====
// Port-level checks for the timer slot table, bound to the top level.
// Depends on ptst_pkg for widths and result kind codes.
`timescale 1ns / 1ps

module ptst_chk
    import ptst_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [KIND_W-1:0]    result_kind,
    input logic [SLOTNUM_W-1:0] slot_number,
    input logic                 success,
    input logic [TAG_W-1:0]     fired_tag,
    input logic                 last_of_run
);

    // A stalled result holds its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_kind)
            && $stable(slot_number) && $stable(success) && $stable(fired_tag)
            && $stable(last_of_run))
        else $error("result changed while stalled");

    // One request in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in work");

    // Fire results succeed and never close a run
    a_fire_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (result_kind == KIND_FIRE) |-> success && !last_of_run)
        else $error("malformed fire result");

    // Every other result closes its run and carries no tag
    a_reply_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (result_kind != KIND_FIRE) |-> last_of_run && (fired_tag == '0))
        else $error("malformed reply or tick-done result");

    // Tick done reports slot zero and success
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (result_kind == KIND_DONE) |-> success && (slot_number == '0))
        else $error("malformed tick-done result");

endmodule

bind periodic_timer_slot_table ptst_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .result_kind (rsp.result_kind),
    .slot_number (rsp.slot_number),
    .success     (rsp.success),
    .fired_tag   (rsp.fired_tag),
    .last_of_run (rsp.last_of_run)
);
